@@ design/q8sf_pkg.sv @@
// Shared types and constants for the eight-node quadrilateral shape function block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package q8sf_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int OP_W          = 2;
  localparam int NODE_W        = 3;
  localparam int COORD_W       = 16;
  localparam int RES_W         = 16;

  typedef enum logic [OP_W-1:0] {
    OP_VALUE = 2'd0,
    OP_DR    = 2'd1,
    OP_DS    = 2'd2
  } op_t;

  // per-request datapath steering, carried down the pipe
  typedef struct packed {
    logic k1_long;  // first rounding by FRAC_BITS+2 instead of FRAC_BITS
    logic sub_one;  // replace x by ONE - x
    logic use_m2;   // second product and rounding
    logic k2_long;  // second rounding by FRAC_BITS+1 instead of FRAC_BITS
    logic half;     // round x by one bit
    logic neg;      // negate the result
  } ctrl_t;

endpackage

`default_nettype wire

@@ design/q8sf_rnd.sv @@
// Symmetric round-to-nearest right shift (halves away from zero), two selectable amounts.
// Standalone, no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module q8sf_rnd #(
  parameter int IW   = 36,
  parameter int OW   = 18,
  parameter int SH_A = 14,
  parameter int SH_B = 16
) (
  input  wire logic signed [IW-1:0] din,
  input  wire logic                 sel_b,
  output logic signed [OW-1:0]      dout
);

  localparam logic [IW:0] HALF_A = {{IW{1'b0}}, 1'b1} << (SH_A - 1);
  localparam logic [IW:0] HALF_B = {{IW{1'b0}}, 1'b1} << (SH_B - 1);

  logic signed [IW:0] dx;
  logic        [IW:0] mag;
  logic        [IW:0] q;
  logic signed [IW:0] qs;

  always_comb begin
    dx   = {din[IW-1], din};
    mag  = dx[IW] ? (-dx) : dx;
    q    = sel_b ? ((mag + HALF_B) >> SH_B) : ((mag + HALF_A) >> SH_A);
    qs   = dx[IW] ? -$signed(q) : $signed(q);
    dout = qs[OW-1:0];
  end

endmodule

`default_nettype wire

@@ design/quad8_shape_function_eval.sv @@
// Top level: eight-node serendipity quadrilateral shape functions and derivatives.
// Depends on q8sf_pkg and q8sf_rnd.
//
// Usage:
//   Input channel (in_valid / in_stall) carries opcode, node_index, coord_r, coord_s.
//   opcode 0 gives N, 1 gives dN/dr, any other value dN/ds. Coordinates are signed
//   fixed point with FRAC_BITS fraction bits, clamped to -1..+1 on entry.
//   Output channel (out_valid / out_stall) carries result_value, saturated to 16 bits.
//   Throughput is one request per cycle while out_stall is low; stages are
//   clamp/decode, first multiply, first rounding, second multiply, final
//   rounding/saturation. The two multipliers in series set the depth.
//   Each stage has its own valid bit and loads whenever it is empty or the stage
//   below moves, so a stall on the output only backs up the pipe as far as it is
//   full; bubbles are squeezed out. in_stall rises only when stage one is occupied
//   and cannot move. Reset clears all valid bits; nothing else needs clearing.
`timescale 1ns / 1ps
`default_nettype none

module quad8_shape_function_eval #(
  parameter int FRAC_BITS = q8sf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [q8sf_pkg::OP_W-1:0]           opcode,
  input  wire logic [q8sf_pkg::NODE_W-1:0]         node_index,
  input  wire logic signed [q8sf_pkg::COORD_W-1:0] coord_r,
  input  wire logic signed [q8sf_pkg::COORD_W-1:0] coord_s,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [q8sf_pkg::RES_W-1:0]        result_value
);

  import q8sf_pkg::*;

  localparam int LW = (FRAC_BITS + 4 > COORD_W + 2) ? FRAC_BITS + 4 : COORD_W + 2;
  localparam int PW = 2 * LW;
  localparam logic signed [LW-1:0] ONE     = {{(LW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [LW-1:0] SAT_MAX = LW'((1 << (RES_W - 1)) - 1);
  localparam logic signed [LW-1:0] SAT_MIN = -(SAT_MAX + {{(LW-1){1'b0}}, 1'b1});

  // stage valids and ready chain
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5 || !out_stall;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  // stage 1: clamp and decode
  logic signed [LW-1:0] m1a_next, m1b_next, y_next;
  ctrl_t                ctrl_next;

  always_comb begin
    logic signed [LW-1:0] rw, sw, rc, sc, rr, ss, a, b, lin;
    logic                 xi_pos, eta_pos;
    rw = {{(LW-COORD_W){coord_r[COORD_W-1]}}, coord_r};
    sw = {{(LW-COORD_W){coord_s[COORD_W-1]}}, coord_s};
    rc = (rw > ONE) ? ONE : ((rw < -ONE) ? -ONE : rw);
    sc = (sw > ONE) ? ONE : ((sw < -ONE) ? -ONE : sw);
    xi_pos  = (node_index == 3'd1) || (node_index == 3'd2) || (node_index == 3'd5);
    eta_pos = (node_index == 3'd2) || (node_index == 3'd3) || (node_index == 3'd6);
    rr  = xi_pos  ? rc : -rc;
    ss  = eta_pos ? sc : -sc;
    a   = ONE + rr;
    b   = ONE + ss;
    lin = '0;
    m1a_next  = a;
    m1b_next  = b;
    y_next    = rr + ss - ONE;
    ctrl_next = '0;
    if (!node_index[2]) begin
      ctrl_next.k1_long = 1'b1;
      priority if (opcode == OP_VALUE) begin
        ctrl_next.use_m2 = 1'b1;
      end else if (opcode == OP_DR) begin
        m1a_next      = b;
        m1b_next      = (rr <<< 1) + ss;
        ctrl_next.neg = !xi_pos;
      end else begin
        m1b_next      = rr + (ss <<< 1);
        ctrl_next.neg = !eta_pos;
      end
    end else if (!node_index[0]) begin
      // midpoints on s = -1 / +1
      lin      = b;
      m1a_next = rc;
      m1b_next = rc;
      y_next   = lin;
      priority if (opcode == OP_VALUE) begin
        ctrl_next.sub_one = 1'b1;
        ctrl_next.use_m2  = 1'b1;
        ctrl_next.k2_long = 1'b1;
      end else if (opcode == OP_DR) begin
        m1b_next      = lin;
        ctrl_next.neg = 1'b1;
      end else begin
        ctrl_next.sub_one = 1'b1;
        ctrl_next.half    = 1'b1;
        ctrl_next.neg     = !eta_pos;
      end
    end else begin
      // midpoints on r = +1 / -1
      lin      = a;
      m1a_next = sc;
      m1b_next = sc;
      y_next   = lin;
      priority if (opcode == OP_VALUE) begin
        ctrl_next.sub_one = 1'b1;
        ctrl_next.use_m2  = 1'b1;
        ctrl_next.k2_long = 1'b1;
      end else if (opcode == OP_DR) begin
        ctrl_next.sub_one = 1'b1;
        ctrl_next.half    = 1'b1;
        ctrl_next.neg     = !xi_pos;
      end else begin
        m1b_next      = lin;
        ctrl_next.neg = 1'b1;
      end
    end
  end

  logic signed [LW-1:0] m1a, m1b, y1;
  ctrl_t                ctrl1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1) begin
      m1a   <= m1a_next;
      m1b   <= m1b_next;
      y1    <= y_next;
      ctrl1 <= ctrl_next;
    end
  end

  // stage 2: first product
  logic signed [PW-1:0] p1_next, p1;
  logic signed [LW-1:0] y2;
  ctrl_t                ctrl2;

  assign p1_next = PW'(m1a) * PW'(m1b);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2) begin
      p1    <= p1_next;
      y2    <= y1;
      ctrl2 <= ctrl1;
    end
  end

  // stage 3: first rounding
  logic signed [LW-1:0] x_rnd, x2_next, x3, y3;
  ctrl_t                ctrl3;

  q8sf_rnd #(
    .IW   (PW),
    .OW   (LW),
    .SH_A (FRAC_BITS),
    .SH_B (FRAC_BITS + 2)
  ) u_rnd1 (
    .din   (p1),
    .sel_b (ctrl2.k1_long),
    .dout  (x_rnd)
  );

  assign x2_next = ctrl2.sub_one ? (ONE - x_rnd) : x_rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3) begin
      x3    <= x2_next;
      y3    <= y2;
      ctrl3 <= ctrl2;
    end
  end

  // stage 4: second product
  logic signed [PW-1:0] p2_next, p2;
  logic signed [LW-1:0] x4;
  ctrl_t                ctrl4;

  assign p2_next = PW'(x3) * PW'(y3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
    if (rdy4) begin
      p2    <= p2_next;
      x4    <= x3;
      ctrl4 <= ctrl3;
    end
  end

  // stage 5: final rounding, sign, saturation
  logic signed [LW-1:0] p2_rnd, x_half, v_sel, v_sgn;
  logic signed [RES_W-1:0] res_next;

  q8sf_rnd #(
    .IW   (PW),
    .OW   (LW),
    .SH_A (FRAC_BITS),
    .SH_B (FRAC_BITS + 1)
  ) u_rnd2 (
    .din   (p2),
    .sel_b (ctrl4.k2_long),
    .dout  (p2_rnd)
  );

  q8sf_rnd #(
    .IW   (LW),
    .OW   (LW),
    .SH_A (1),
    .SH_B (1)
  ) u_rnd_half (
    .din   (x4),
    .sel_b (ctrl4.half),
    .dout  (x_half)
  );

  always_comb begin
    v_sel = ctrl4.use_m2 ? p2_rnd : (ctrl4.half ? x_half : x4);
    v_sgn = ctrl4.neg ? -v_sel : v_sel;
    priority if (v_sgn > SAT_MAX) begin
      res_next = SAT_MAX[RES_W-1:0];
    end else if (v_sgn < SAT_MIN) begin
      res_next = SAT_MIN[RES_W-1:0];
    end else begin
      res_next = v_sgn[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (rdy5) begin
      v5 <= v4;
    end
    if (rdy5) begin
      result_value <= res_next;
    end
  end

  assign out_valid = v5;

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3 && v4 && v5 && out_stall))
    else $error("input stalled while pipe has room");

  a_accept_lands_s1: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v1)
    else $error("accepted request missing from stage one");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
      |=> out_valid)
    else $error("request did not reach output after five free cycles");

endmodule

`default_nettype wire
